// ===== design/otag_pkg.sv =====
package otag_pkg;

  // field widths
  localparam int GROUP_W = 22;
  localparam int SLOT_W  = 4;
  localparam int POS_W   = 6;
  localparam int ADDR_W  = 22;
  localparam int LANE_W  = 4;
  localparam int DIM_W   = 13;
  localparam int TSZ_W   = 7;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = DIM_W;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_COLS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_ROWS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TILES_ACROSS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TILES_DOWN   = 3'd5;

  // register reset values
  localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 13'd256;
  localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 13'd256;
  localparam logic [TSZ_W-1:0] RST_TILE_COLS    = 7'd32;
  localparam logic [TSZ_W-1:0] RST_TILE_ROWS    = 7'd32;
  localparam logic [DIM_W-1:0] RST_TILES_ACROSS = 13'd9;

  // parameter defaults
  localparam int LANES_PER_WORD_DEF = 4;
  localparam int KERNEL_COUNT_DEF   = 7;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // live configuration seen by the back end
  typedef struct packed {
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic [TSZ_W-1:0] tile_cols;
    logic [TSZ_W-1:0] tile_rows;
    logic [DIM_W-1:0] tiles_across;
  } cfg_t;

  // width of the tile number group * kernel_count + slot
  function automatic int tile_w(input int kernel_count);
    return GROUP_W + $clog2(kernel_count) + 1;
  endfunction

endpackage

// ===== design/otag_queue.sv =====
module otag_queue #(
  parameter int W     = 8,
  parameter int DEPTH = otag_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW:0]   wr_ptr_r;
  logic [AW:0]   rd_ptr_r;
  logic          do_push;
  logic          do_pop;

  // status from pointer compare, extra bit tells wrap
  assign empty   = (wr_ptr_r == rd_ptr_r);
  assign full    = (wr_ptr_r[AW] != rd_ptr_r[AW]) &&
                   (wr_ptr_r[AW-1:0] == rd_ptr_r[AW-1:0]);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r[AW-1:0]];

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r[AW-1:0]] <= wdata;
    end
  end

endmodule

// ===== design/otag_front.sv =====
module otag_front #(
  parameter int KERNEL_COUNT = otag_pkg::KERNEL_COUNT_DEF,
  parameter int QW           = otag_pkg::tile_w(KERNEL_COUNT) + 2 * otag_pkg::POS_W
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [otag_pkg::GROUP_W-1:0] in_group_index,
  input  logic [otag_pkg::SLOT_W-1:0]  in_kernel_slot,
  input  logic [otag_pkg::POS_W-1:0]   in_row_in_tile,
  input  logic [otag_pkg::POS_W-1:0]   in_col_in_tile,
  output logic                         q_push,
  output logic [QW-1:0]                q_data,
  input  logic                         q_full
);

  localparam int TILE_W = otag_pkg::tile_w(KERNEL_COUNT);

  logic                       valid_r;
  logic                       valid_nxt;
  logic [TILE_W-1:0]          tile_r;
  logic [TILE_W-1:0]          tile_nxt;
  logic [otag_pkg::POS_W-1:0] row_r;
  logic [otag_pkg::POS_W-1:0] col_r;
  logic                       load;

  // input stage holds while the queue is full
  assign in_full = valid_r && q_full;
  assign load    = in_push && !in_full;
  assign q_push  = valid_r && !q_full;
  assign q_data  = {tile_r, row_r, col_r};

  // linear tile number
  assign tile_nxt = TILE_W'(in_group_index) * TILE_W'(KERNEL_COUNT) +
                    TILE_W'(in_kernel_slot);

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (q_push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tile_r <= tile_nxt;
      row_r  <= in_row_in_tile;
      col_r  <= in_col_in_tile;
    end
  end

endmodule

// ===== design/otag_back.sv =====
module otag_back #(
  parameter int LANES_PER_WORD = otag_pkg::LANES_PER_WORD_DEF,
  parameter int KERNEL_COUNT   = otag_pkg::KERNEL_COUNT_DEF,
  parameter int QW             = otag_pkg::tile_w(KERNEL_COUNT) + 2 * otag_pkg::POS_W
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  otag_pkg::cfg_t              cfg,
  input  logic                        q_empty,
  input  logic [QW-1:0]               q_data,
  output logic                        q_pop,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [otag_pkg::ADDR_W-1:0] out_word_address,
  output logic [otag_pkg::LANE_W-1:0] out_lane,
  output logic                        out_pad_zero
);

  localparam int TILE_W = otag_pkg::tile_w(KERNEL_COUNT);
  localparam int POS_W  = otag_pkg::POS_W;
  localparam int DIM_W  = otag_pkg::DIM_W;
  localparam int TSZ_W  = otag_pkg::TSZ_W;
  localparam int PX_W   = DIM_W + TSZ_W + 1;
  localparam int PY_W   = TILE_W + TSZ_W + 1;
  localparam int IDX_W  = 2 * DIM_W;
  localparam int LG_L   = $clog2(LANES_PER_WORD);
  localparam int DIV_SH = IDX_W + LG_L;
  localparam int M_W    = IDX_W + 1;
  localparam int PROD_W = IDX_W + M_W;
  localparam logic [M_W-1:0] RECIP =
    M_W'(((64'd1 << DIV_SH) + 64'(LANES_PER_WORD) - 64'd1) / 64'(LANES_PER_WORD));

  // whole pipeline moves together unless the result word is held
  logic adv;
  assign adv   = out_empty || out_pop;
  assign q_pop = adv && !q_empty;

  // derived configuration
  logic [DIM_W-1:0] divisor;
  logic [TSZ_W-1:0] step_x;
  logic [TSZ_W-1:0] step_y;
  assign divisor = (cfg.tiles_across == '0) ? DIM_W'(1) : cfg.tiles_across;
  assign step_x  = (cfg.tile_cols >= TSZ_W'(2)) ? cfg.tile_cols - TSZ_W'(2) : '0;
  assign step_y  = (cfg.tile_rows >= TSZ_W'(2)) ? cfg.tile_rows - TSZ_W'(2) : '0;

  // edge rule: {ok, clamped coordinate}
  function automatic logic [DIM_W:0] edge_clamp(input logic [PY_W-1:0] pos,
                                                input logic [DIM_W-1:0] size);
    logic [PY_W-1:0] size_x;
    size_x = PY_W'(size);
    if (size == '0) begin
      return '0;
    end else if (pos < size_x) begin
      return {1'b1, pos[DIM_W-1:0]};
    end else if (pos == size_x) begin
      return {1'b1, size - DIM_W'(1)};
    end else begin
      return '0;
    end
  endfunction

  // restoring divider, one quotient bit per stage
  logic                dv_valid_r [0:TILE_W];
  logic [DIM_W-1:0]    dv_rem_r   [0:TILE_W];
  logic [TILE_W-1:0]   dv_nq_r    [0:TILE_W];
  logic [POS_W-1:0]    dv_row_r   [0:TILE_W];
  logic [POS_W-1:0]    dv_col_r   [0:TILE_W];

  // load stage from the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_valid_r[0] <= 1'b0;
    end else if (adv) begin
      dv_valid_r[0] <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rem_r[0] <= '0;
      dv_nq_r[0]  <= q_data[QW-1 -: TILE_W];
      dv_row_r[0] <= q_data[2*POS_W-1 -: POS_W];
      dv_col_r[0] <= q_data[POS_W-1:0];
    end
  end

  for (genvar i = 1; i <= TILE_W; i++) begin : g_div
    logic [DIM_W:0] trial;
    logic           ge;

    assign trial = {dv_rem_r[i-1], dv_nq_r[i-1][TILE_W-1]};
    assign ge    = trial >= {1'b0, divisor};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_valid_r[i] <= 1'b0;
      end else if (adv) begin
        dv_valid_r[i] <= dv_valid_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem_r[i] <= ge ? DIM_W'(trial - {1'b0, divisor}) : trial[DIM_W-1:0];
        dv_nq_r[i]  <= {dv_nq_r[i-1][TILE_W-2:0], ge};
        dv_row_r[i] <= dv_row_r[i-1];
        dv_col_r[i] <= dv_col_r[i-1];
      end
    end
  end

  // pixel position from tile position and step
  logic            a_valid_r;
  logic [PX_W-1:0] px_r;
  logic [PX_W-1:0] px_nxt;
  logic [PY_W-1:0] py_r;
  logic [PY_W-1:0] py_nxt;

  assign px_nxt = PX_W'(PX_W'(dv_rem_r[TILE_W]) * PX_W'(step_x)) + PX_W'(dv_col_r[TILE_W]);
  assign py_nxt = PY_W'(PY_W'(dv_nq_r[TILE_W]) * PY_W'(step_y)) + PY_W'(dv_row_r[TILE_W]);

  // edge replicate or zero pad
  logic             b_valid_r;
  logic [DIM_W-1:0] cx_r;
  logic [DIM_W-1:0] cy_r;
  logic             b_pad_r;
  logic [DIM_W:0]   ex_nxt;
  logic [DIM_W:0]   ey_nxt;

  assign ex_nxt = edge_clamp(PY_W'(px_r), cfg.image_width);
  assign ey_nxt = edge_clamp(py_r, cfg.image_height);

  // linear pixel index
  logic             c_valid_r;
  logic [IDX_W-1:0] c_idx_r;
  logic             c_pad_r;
  logic [IDX_W-1:0] idx_nxt;

  assign idx_nxt = IDX_W'(IDX_W'(cy_r) * IDX_W'(cfg.image_width)) + IDX_W'(cx_r);

  // word index by reciprocal multiply
  logic              d_valid_r;
  logic [IDX_W-1:0]  d_idx_r;
  logic [IDX_W-1:0]  d_q_r;
  logic              d_pad_r;
  logic [PROD_W-1:0] prod;
  logic [IDX_W-1:0]  q_nxt;

  assign prod  = PROD_W'(c_idx_r) * PROD_W'(RECIP);
  assign q_nxt = IDX_W'(prod >> DIV_SH);

  // lane and result word
  logic                        e_valid_r;
  logic [otag_pkg::ADDR_W-1:0] addr_r;
  logic [otag_pkg::LANE_W-1:0] lane_r;
  logic                        e_pad_r;
  logic [IDX_W-1:0]            rem_nxt;

  assign rem_nxt = d_idx_r - IDX_W'(d_q_r * IDX_W'(LANES_PER_WORD));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
      e_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= dv_valid_r[TILE_W];
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
      d_valid_r <= c_valid_r;
      e_valid_r <= d_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      cx_r    <= ex_nxt[DIM_W-1:0];
      cy_r    <= ey_nxt[DIM_W-1:0];
      b_pad_r <= !(ex_nxt[DIM_W] && ey_nxt[DIM_W]);
      c_idx_r <= idx_nxt;
      c_pad_r <= b_pad_r;
      d_idx_r <= c_idx_r;
      d_q_r   <= q_nxt;
      d_pad_r <= c_pad_r;
      addr_r  <= d_pad_r ? '0 : d_q_r[otag_pkg::ADDR_W-1:0];
      lane_r  <= d_pad_r ? '0 : rem_nxt[otag_pkg::LANE_W-1:0];
      e_pad_r <= d_pad_r;
    end
  end

  assign out_empty        = !e_valid_r;
  assign out_word_address = addr_r;
  assign out_lane         = lane_r;
  assign out_pad_zero     = e_pad_r;

endmodule

// ===== design/overlap_tile_address_generator_unit.sv =====
// Overlapping tile address generator with edge padding.
// Input words (group index, kernel slot, row and column inside the tile) are
// pushed while in_full is low; each gives one result word (bus word address,
// lane, pad flag) read from the result side while out_empty is low, taken by
// out_pop. Tile geometry and image size come from the cfg_ write port, which
// is to be written only while no words are in flight; the block itself does
// not enforce this. Throughput is one word per cycle unless results are held.
// A word passes the input stage, the queue, the load stage, the divider, then
// the position, edge, index, word and lane stages. The divider is a pipelined
// restoring divider splitting the tile number by tiles_across, one quotient bit
// per stage over its tile_w = 23 + clog2(KERNEL_COUNT) bits.
// A four-word queue parts the input stage from the divider and address
// pipeline. While a result waits and out_pop is low the whole back pipeline
// holds; inputs are still taken until the queue and input stage fill, then
// in_full rises. Reset empties all stages and loads the register defaults.
module overlap_tile_address_generator_unit #(
  parameter int LANES_PER_WORD = otag_pkg::LANES_PER_WORD_DEF,
  parameter int KERNEL_COUNT   = otag_pkg::KERNEL_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [otag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [otag_pkg::CFG_DATA_W-1:0] cfg_data,
  // input words
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [otag_pkg::GROUP_W-1:0]    in_group_index,
  input  logic [otag_pkg::SLOT_W-1:0]     in_kernel_slot,
  input  logic [otag_pkg::POS_W-1:0]      in_row_in_tile,
  input  logic [otag_pkg::POS_W-1:0]      in_col_in_tile,
  // result words
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [otag_pkg::ADDR_W-1:0]     out_word_address,
  output logic [otag_pkg::LANE_W-1:0]     out_lane,
  output logic                            out_pad_zero
);

  localparam int QW = otag_pkg::tile_w(KERNEL_COUNT) + 2 * otag_pkg::POS_W;

  otag_pkg::cfg_t cfg_r;

  // configuration registers; tiles_down is accepted but not needed here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= otag_pkg::RST_IMAGE_WIDTH;
      cfg_r.image_height <= otag_pkg::RST_IMAGE_HEIGHT;
      cfg_r.tile_cols    <= otag_pkg::RST_TILE_COLS;
      cfg_r.tile_rows    <= otag_pkg::RST_TILE_ROWS;
      cfg_r.tiles_across <= otag_pkg::RST_TILES_ACROSS;
    end else if (cfg_we) begin
      case (cfg_index)
        otag_pkg::REG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_data;
        otag_pkg::REG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_data;
        otag_pkg::REG_TILE_COLS:    cfg_r.tile_cols    <= cfg_data[otag_pkg::TSZ_W-1:0];
        otag_pkg::REG_TILE_ROWS:    cfg_r.tile_rows    <= cfg_data[otag_pkg::TSZ_W-1:0];
        otag_pkg::REG_TILES_ACROSS: cfg_r.tiles_across <= cfg_data;
        otag_pkg::REG_TILES_DOWN:   ;
        default:                    ;
      endcase
    end
  end

  logic          q_push;
  logic [QW-1:0] q_wdata;
  logic          q_full;
  logic          q_pop;
  logic [QW-1:0] q_rdata;
  logic          q_empty;

  // front: input stage and tile number
  otag_front #(
    .KERNEL_COUNT (KERNEL_COUNT),
    .QW           (QW)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_group_index (in_group_index),
    .in_kernel_slot (in_kernel_slot),
    .in_row_in_tile (in_row_in_tile),
    .in_col_in_tile (in_col_in_tile),
    .q_push         (q_push),
    .q_data         (q_wdata),
    .q_full         (q_full)
  );

  // queue between front and back
  otag_queue #(
    .W     (QW),
    .DEPTH (otag_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // back: divider and address pipeline
  otag_back #(
    .LANES_PER_WORD (LANES_PER_WORD),
    .KERNEL_COUNT   (KERNEL_COUNT),
    .QW             (QW)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_empty          (q_empty),
    .q_data           (q_rdata),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_word_address (out_word_address),
    .out_lane         (out_lane),
    .out_pad_zero     (out_pad_zero)
  );

endmodule

// ===== bench/overlap_tile_address_generator_unit_tb.sv =====
module overlap_tile_address_generator_unit_tb;

  localparam int KCOUNT         = otag_pkg::KERNEL_COUNT_DEF;
  localparam int LANES          = otag_pkg::LANES_PER_WORD_DEF;
  localparam int GROUP_W        = otag_pkg::GROUP_W;
  localparam int SLOT_W         = otag_pkg::SLOT_W;
  localparam int POS_W          = otag_pkg::POS_W;
  localparam int ADDR_W         = otag_pkg::ADDR_W;
  localparam int LANE_W         = otag_pkg::LANE_W;
  localparam int DIM_W          = otag_pkg::DIM_W;
  localparam int TSZ_W          = otag_pkg::TSZ_W;
  localparam int CFG_IDX_W      = otag_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W     = otag_pkg::CFG_DATA_W;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_WORDS    = 125;
  localparam int MAX_PRINTED    = 50;

  typedef longint unsigned u64_t;

  // one pixel request plus the idle cycles the sender waits after it
  typedef struct packed {
    logic [GROUP_W-1:0] group_index;
    logic [SLOT_W-1:0]  kernel_slot;
    logic [POS_W-1:0]   row_in_tile;
    logic [POS_W-1:0]   col_in_tile;
    logic [2:0]         gap;
  } pixel_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] word_address;
    logic [LANE_W-1:0] lane;
    logic              pad_zero;
  } pixel_loc_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = otag_pkg::REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_push   = 1'b0;
  logic                  in_full;
  logic [GROUP_W-1:0]    in_group_index = '0;
  logic [SLOT_W-1:0]     in_kernel_slot = '0;
  logic [POS_W-1:0]      in_row_in_tile = '0;
  logic [POS_W-1:0]      in_col_in_tile = '0;
  logic                  out_empty;
  logic                  out_pop   = 1'b0;
  logic [ADDR_W-1:0]     out_word_address;
  logic [LANE_W-1:0]     out_lane;
  logic                  out_pad_zero;

  // mirrored geometry registers
  logic [DIM_W-1:0] geo_image_width  = otag_pkg::RST_IMAGE_WIDTH;
  logic [DIM_W-1:0] geo_image_height = otag_pkg::RST_IMAGE_HEIGHT;
  logic [TSZ_W-1:0] geo_tile_cols    = otag_pkg::RST_TILE_COLS;
  logic [TSZ_W-1:0] geo_tile_rows    = otag_pkg::RST_TILE_ROWS;
  logic [DIM_W-1:0] geo_tiles_across = otag_pkg::RST_TILES_ACROSS;

  pixel_req_t pending_pixels[$];
  pixel_loc_t pixel_expect[$];
  pixel_req_t launched;
  pixel_loc_t want_loc;
  int         mismatch_count = 0;
  int         quiet_cycles   = 0;
  logic [2:0] send_wait      = '0;
  int         send_stretch   = 0;
  bit         send_calm      = 1'b0;
  logic [2:0] pop_wait       = '0;
  int         pop_stretch    = 0;
  bit         pop_calm       = 1'b0;
  int         pop_draw;

  overlap_tile_address_generator_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_group_index   (in_group_index),
    .in_kernel_slot   (in_kernel_slot),
    .in_row_in_tile   (in_row_in_tile),
    .in_col_in_tile   (in_col_in_tile),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_word_address (out_word_address),
    .out_lane         (out_lane),
    .out_pad_zero     (out_pad_zero)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // one past the edge replicates the last pixel, further out pads
  function automatic bit clamp_edge(input u64_t pos, input u64_t size, output u64_t clamped);
    clamped = 0;
    if (size == 0 || pos > size) return 1'b0;
    clamped = (pos == size) ? size - 1 : pos;
    return 1'b1;
  endfunction

  // where a pixel slot lands in memory under the current geometry
  function automatic pixel_loc_t locate_pixel(input pixel_req_t p);
    u64_t       across, tile, tx, ty, step_x, step_y, px, py, cx, cy, idx;
    bit         in_x, in_y;
    pixel_loc_t loc;
    across = (geo_tiles_across == '0) ? 1 : u64_t'(geo_tiles_across);
    tile   = u64_t'(p.group_index) * u64_t'(KCOUNT) + u64_t'(p.kernel_slot);
    tx     = tile % across;
    ty     = tile / across;
    step_x = (geo_tile_cols >= 2) ? u64_t'(geo_tile_cols) - 2 : 0;
    step_y = (geo_tile_rows >= 2) ? u64_t'(geo_tile_rows) - 2 : 0;
    px     = tx * step_x + u64_t'(p.col_in_tile);
    py     = ty * step_y + u64_t'(p.row_in_tile);
    in_x   = clamp_edge(px, u64_t'(geo_image_width), cx);
    in_y   = clamp_edge(py, u64_t'(geo_image_height), cy);
    loc    = '0;
    if (in_x && in_y) begin
      idx              = cy * u64_t'(geo_image_width) + cx;
      loc.word_address = ADDR_W'(idx / u64_t'(LANES));
      loc.lane         = LANE_W'(idx % u64_t'(LANES));
    end else begin
      loc.pad_zero = 1'b1;
    end
    return loc;
  endfunction

  task automatic flag_mismatch(input string what);
    if (mismatch_count < MAX_PRINTED) $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      otag_pkg::REG_IMAGE_WIDTH:  geo_image_width  = val;
      otag_pkg::REG_IMAGE_HEIGHT: geo_image_height = val;
      otag_pkg::REG_TILE_COLS:    geo_tile_cols    = val[TSZ_W-1:0];
      otag_pkg::REG_TILE_ROWS:    geo_tile_rows    = val[TSZ_W-1:0];
      otag_pkg::REG_TILES_ACROSS: geo_tiles_across = val;
      default: ;
    endcase
  endtask

  // rewrite the whole geometry; only called with nothing in flight
  task automatic program_geometry(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                                  input logic [CFG_DATA_W-1:0] tc, input logic [CFG_DATA_W-1:0] tr,
                                  input logic [CFG_DATA_W-1:0] ta, input logic [CFG_DATA_W-1:0] td);
    put_reg(otag_pkg::REG_IMAGE_WIDTH, w);
    put_reg(otag_pkg::REG_IMAGE_HEIGHT, h);
    put_reg(otag_pkg::REG_TILE_COLS, tc);
    put_reg(otag_pkg::REG_TILE_ROWS, tr);
    put_reg(otag_pkg::REG_TILES_ACROSS, ta);
    put_reg(otag_pkg::REG_TILES_DOWN, td);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_pixels.size() != 0 || in_push || pixel_expect.size() != 0);
  endtask

  // sender gaps come in stretches, some of them with no idling at all
  task automatic queue_pixel(input logic [GROUP_W-1:0] g, input logic [SLOT_W-1:0] s,
                             input logic [POS_W-1:0] r, input logic [POS_W-1:0] c);
    pixel_req_t p;
    if (send_stretch == 0) begin
      send_stretch = $urandom_range(8, 40);
      send_calm    = ($urandom_range(0, 2) == 0);
    end
    send_stretch--;
    p.group_index = g;
    p.kernel_slot = s;
    p.row_in_tile = r;
    p.col_in_tile = c;
    p.gap         = send_calm ? 3'd0 : 3'($urandom_range(0, 4));
    pending_pixels.push_back(p);
  endtask

  task automatic queue_tile(input u64_t tile, input logic [POS_W-1:0] r,
                            input logic [POS_W-1:0] c);
    queue_pixel(GROUP_W'(tile / u64_t'(KCOUNT)), SLOT_W'(tile % u64_t'(KCOUNT)), r, c);
  endtask

  // driver: launch the next word once the previous one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push   <= 1'b0;
      send_wait <= '0;
    end else if (!in_push || !in_full) begin
      if (in_push) pixel_expect.push_back(locate_pixel(launched));
      if (send_wait != '0) begin
        in_push   <= 1'b0;
        send_wait <= send_wait - 3'd1;
      end else if (pending_pixels.size() != 0) begin
        launched = pending_pixels.pop_front();
        in_push        <= 1'b1;
        in_group_index <= launched.group_index;
        in_kernel_slot <= launched.kernel_slot;
        in_row_in_tile <= launched.row_in_tile;
        in_col_in_tile <= launched.col_in_tile;
        send_wait      <= launched.gap;
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // monitor: check each result word against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop  <= 1'b0;
      pop_wait <= '0;
    end else if (out_pop && !out_empty) begin
      if (pixel_expect.size() == 0) begin
        flag_mismatch($sformatf("unexpected word addr %0d lane %0d pad %0b",
                                out_word_address, out_lane, out_pad_zero));
      end else begin
        want_loc = pixel_expect.pop_front();
        if (out_word_address !== want_loc.word_address || out_lane !== want_loc.lane ||
            out_pad_zero !== want_loc.pad_zero)
          flag_mismatch($sformatf("got addr %0d lane %0d pad %0b, want addr %0d lane %0d pad %0b",
                                  out_word_address, out_lane, out_pad_zero,
                                  want_loc.word_address, want_loc.lane, want_loc.pad_zero));
      end
      if (pop_stretch == 0) begin
        pop_stretch = $urandom_range(8, 40);
        pop_calm    = ($urandom_range(0, 2) == 0);
      end
      pop_stretch--;
      pop_draw = pop_calm ? 0 : $urandom_range(0, 4);
      if (pop_draw == 0) begin
        out_pop <= 1'b1;
      end else begin
        out_pop  <= 1'b0;
        pop_wait <= 3'(pop_draw - 1);
      end
    end else if (!out_pop) begin
      if (pop_wait == '0) out_pop <= 1'b1;
      else pop_wait <= pop_wait - 3'd1;
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL overlap_tile_address_generator_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int   w, h, tc, tr, ta, td, tx, ty;
    u64_t tile;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset geometry: 30 pixel steps, nine tiles across
    queue_pixel('0, '0, '0, '0);
    queue_pixel('1, '1, '1, '1);
    queue_tile(6, 6'd5, 6'd7);
    queue_pixel('0, 4'd7, '0, '0);
    queue_pixel(22'd1, 4'd15, 6'd2, 6'd3);
    // right edge replicated, then padded
    queue_tile(8, 6'd0, 6'd16);
    queue_tile(8, 6'd0, 6'd17);
    // bottom edge replicated, then padded
    queue_tile(72, 6'd16, 6'd0);
    queue_tile(72, 6'd17, 6'd0);
    // bottom right corner
    queue_tile(80, 6'd16, 6'd16);
    queue_tile(80, 6'd15, 6'd15);
    // position past the tile size
    queue_pixel('0, '0, 6'd63, 6'd40);
    queue_tile(10, 6'd3, 6'd1);
    wait_idle();

    // all ones in every register; the last word overflows the address
    program_geometry('1, '1, '1, '1, '1, '1);
    queue_pixel('0, '0, '0, '0);
    queue_pixel('1, '1, '1, '1);
    queue_tile(u64_t'(17 * 8191 + 65), 6'd63, 6'd63);
    wait_idle();

    // empty image, zero tiles across, tiles smaller than the overlap
    program_geometry(13'd0, 13'd5, 13'h80, 13'd1, 13'd0, 13'd0);
    queue_pixel('0, '0, '0, '0);
    queue_tile(3, 6'd4, 6'd2);
    wait_idle();
    program_geometry(13'd5, 13'd5, 13'h81, 13'd2, 13'd0, 13'd0);
    queue_tile(9, 6'd4, 6'd5);
    queue_tile(2, 6'd6, 6'd0);
    wait_idle();

    // smallest legal geometry
    program_geometry(13'd1, 13'd1, 13'd3, 13'd3, 13'd1, 13'd1);
    queue_tile(0, 6'd0, 6'd0);
    queue_tile(0, 6'd0, 6'd1);
    queue_tile(0, 6'd0, 6'd2);
    queue_tile(1, 6'd0, 6'd0);
    wait_idle();

    // random geometries, words aimed mostly at real tiles near the edges
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      tc = $urandom_range(3, 64);
      tr = $urandom_range(3, 64);
      w  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 300);
      h  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 300);
      ta = (w + tc - 3) / (tc - 2) + $urandom_range(0, 1);
      td = (h + tr - 3) / (tr - 2) + $urandom_range(0, 1);
      program_geometry(13'(w), 13'(h), 13'(tc), 13'(tr), 13'(ta), 13'(td));
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(0, 4) == 0) begin
          queue_pixel(GROUP_W'($urandom), SLOT_W'($urandom), POS_W'($urandom),
                      POS_W'($urandom));
        end else begin
          tx   = ($urandom_range(0, 1) == 0) ? ta - 1 : $urandom_range(0, ta - 1);
          ty   = ($urandom_range(0, 1) == 0) ? $urandom_range(td - 1, td)
                                             : $urandom_range(0, td);
          tile = u64_t'(ty) * u64_t'(ta) + u64_t'(tx);
          queue_tile(tile, POS_W'($urandom_range(0, tr - 1)), POS_W'($urandom_range(0, tc - 1)));
        end
      end
      wait_idle();
    end

    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS overlap_tile_address_generator_unit");
    end else begin
      $display("FAIL overlap_tile_address_generator_unit");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/otag_pkg.sv
design/otag_queue.sv
design/otag_front.sv
design/otag_back.sv
design/overlap_tile_address_generator_unit.sv
bench/overlap_tile_address_generator_unit_tb.sv
